// File: src/iph_pkg.sv
// Package with the constants, codes and types of the indexed priority heap.
`timescale 1ns / 1ps
package iph_pkg;
    localparam int CAPACITY     = 256;
    localparam int HANDLE_COUNT = 256;
    localparam int KEY_BITS     = 32;
    localparam int SLOT_BITS    = $clog2(CAPACITY);
    localparam int CNT_BITS     = $clog2(CAPACITY + 1);
    localparam int HANDLE_BITS  = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_POPPED    = 3'd1,
        ST_NONE      = 3'd2,
        ST_FULL      = 3'd3,
        ST_BADHANDLE = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] hnd;
    } t_entry;
endpackage

// File: src/indexed_priority_heap.sv
// Top level of the indexed priority heap: control sequencer and slot and position memories.
`timescale 1ns / 1ps
// Indexed priority heap of (key, handle) pairs.
// Items enter on the s_axis group: tdata holds opcode [1:0], key [33:2] and
// handle [41:34], padded to 48 bits. One result leaves on the m_axis group for
// every item: status [2:0], popped handle [10:3] and entry count [19:11].
// The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
// the order bit: 0 puts the largest key at the root, 1 the smallest. It is
// accepted only while the block is idle with no result waiting.
// The block works on one item at a time. The slot memory has one registered
// read port and the sift keeps the moving entry in a register, so a level
// going up takes the states read parent and compare, and a level going down
// the states read left, read right, and compare and write back.
// The result is valid once the item is through: an item that is refused or
// does nothing goes straight to the result, an insert may sift up to the root
// and a pop may sift the last entry from the root down to a leaf. The next
// item can be accepted at the edge where the result is taken.
// A stalled receiver holds the single result register and, with it, the input.
// Reset (synchronous, active low) empties the heap and clears the presence
// bits at once; no clearing pass is needed.
module indexed_priority_heap
    import iph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // opcode, key, handle, zero padding
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, popped_handle, entry_count, padding
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_RD0   = 12'b000000000010,  // read slot 0 for pop
        S_CHK   = 12'b000000000100,  // pop compare
        S_RDL   = 12'b000000001000,  // read last slot
        S_MOVE  = 12'b000000010000,  // last entry becomes the moving entry
        S_URD   = 12'b000000100000,  // sift up: read parent
        S_UCMP  = 12'b000001000000,  // sift up: compare with parent
        S_DRDL  = 12'b000010000000,  // sift down: read left
        S_DRDR  = 12'b000100000000,  // read right
        S_DCMP  = 12'b001000000000,
        S_DONE  = 12'b010000000000,
        S_UFIN  = 12'b100000000000   // moving entry written into slot 0
    } t_state;

    // Slot memory and handle position memory.
    t_entry                 r_slots [CAPACITY];
    logic [SLOT_BITS-1:0]   r_pos   [HANDLE_COUNT];
    logic [HANDLE_COUNT-1:0] r_present;

    t_state               r_state;
    logic                 r_dir;
    logic [CNT_BITS-1:0]  r_count;
    t_opcode              r_op;
    t_entry               r_cur;      // entry being sifted
    logic [SLOT_BITS-1:0] r_at;       // the free slot it will land in
    logic [SLOT_BITS-1:0] r_best;     // left child slot
    t_entry               r_bestent;  // left child entry
    logic                 r_haver;
    logic [KEY_BITS-1:0]  r_thr;
    logic                 r_ovalid;
    t_status              r_ostatus;
    logic [HANDLE_BITS-1:0] r_opop;

    // Memory port controls.
    logic                 s_rd_en;
    logic [SLOT_BITS-1:0] s_rd_addr;
    t_entry               r_rd_data;
    logic                 s_wr_en;
    logic [SLOT_BITS-1:0] s_wr_addr;
    t_entry               s_wr_data;
    logic                 s_prd_en;
    logic [SLOT_BITS-1:0] r_prd_data;

    logic [CNT_BITS-1:0]  s_left;
    logic [CNT_BITS:0]    s_right;
    logic [SLOT_BITS-1:0] s_parent;
    logic                 s_take;
    logic                 s_pick_right;
    t_entry               s_best_ent;
    logic [SLOT_BITS-1:0] s_best_idx;

    logic [1:0]             s_in_op;
    logic [KEY_BITS-1:0]    s_in_key;
    logic [HANDLE_BITS-1:0] s_in_hnd;

    function automatic logic ahead(input logic dir, input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b);
        logic gt;
        logic lt;
        gt = $signed(a) > $signed(b);
        lt = $signed(a) < $signed(b);
        return dir ? lt : gt;
    endfunction

    assign s_in_op  = s_axis_tdata[1:0];
    assign s_in_key = s_axis_tdata[33:2];
    assign s_in_hnd = s_axis_tdata[41:34];

    assign o_cfg_ready   = (r_state == S_IDLE) && !r_ovalid;
    assign s_take        = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && s_take;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_count, r_opop, r_ostatus};

    assign s_left   = {r_at, 1'b1};
    assign s_right  = {1'b0, s_left} + (CNT_BITS + 1)'(1);
    assign s_parent = SLOT_BITS'((r_at - 1'b1) >> 1);

    // Child choice: the right child wins only when strictly ahead of the left.
    assign s_pick_right = r_haver && ahead(r_dir, r_rd_data.key, r_bestent.key);
    assign s_best_ent   = s_pick_right ? r_rd_data : r_bestent;
    assign s_best_idx   = s_pick_right ? (r_best + SLOT_BITS'(1)) : r_best;

    always_ff @(posedge i_clk) begin
        if (s_rd_en) begin
            r_rd_data <= r_slots[s_rd_addr];
        end
        if (s_wr_en) begin
            r_slots[s_wr_addr] <= s_wr_data;
            r_pos[s_wr_data.hnd] <= s_wr_addr;
        end
        if (s_prd_en) begin
            r_prd_data <= r_pos[s_in_hnd];
        end
    end

    always_comb begin
        s_rd_en   = 1'b0;
        s_rd_addr = '0;
        s_wr_en   = 1'b0;
        s_wr_addr = r_at;
        s_wr_data = r_cur;
        s_prd_en  = (r_state == S_IDLE);
        unique case (r_state)
            S_RD0: begin
                s_rd_en = 1'b1;
            end
            S_RDL: begin
                s_rd_en   = 1'b1;
                s_rd_addr = SLOT_BITS'(r_count);
            end
            S_URD: begin
                s_rd_en   = 1'b1;
                s_rd_addr = s_parent;
            end
            S_UCMP: begin
                // The parent moves down into the free slot on a swap; an
                // insert that stops here lands its entry in the free slot.
                if (ahead(r_dir, r_cur.key, r_rd_data.key)) begin
                    s_wr_en   = 1'b1;
                    s_wr_data = r_rd_data;
                end else if (r_op == OP_INSERT) begin
                    s_wr_en = 1'b1;
                end
            end
            S_UFIN: begin
                s_wr_en = 1'b1;
            end
            S_DRDL: begin
                if (s_left >= r_count) begin
                    s_wr_en = 1'b1;
                end else begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = SLOT_BITS'(s_left);
                end
            end
            S_DRDR: begin
                if (s_right < {1'b0, r_count}) begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = SLOT_BITS'(s_right);
                end
            end
            S_DCMP: begin
                s_wr_en = 1'b1;
                if (ahead(r_dir, s_best_ent.key, r_cur.key)) begin
                    s_wr_data = s_best_ent;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dir     <= 1'b0;
            r_count   <= '0;
            r_present <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_dir <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_take) begin
                        r_op   <= t_opcode'(s_in_op);
                        r_thr  <= s_in_key;
                        r_cur  <= '{key: s_in_key, hnd: s_in_hnd};
                        r_opop <= '0;
                        unique case (t_opcode'(s_in_op))
                            OP_INSERT: begin
                                if (r_present[s_in_hnd]) begin
                                    r_ostatus <= ST_BADHANDLE;
                                    r_state   <= S_DONE;
                                end else if (r_count >= CNT_BITS'(CAPACITY)) begin
                                    r_ostatus <= ST_FULL;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_ostatus <= ST_DONE;
                                    r_present[s_in_hnd] <= 1'b1;
                                    r_at    <= SLOT_BITS'(r_count);
                                    r_count <= r_count + 1'b1;
                                    r_state <= (r_count == '0) ? S_UFIN : S_URD;
                                end
                            end
                            OP_REMOVE: begin
                                if (!r_present[s_in_hnd]) begin
                                    r_ostatus <= ST_BADHANDLE;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_ostatus <= ST_DONE;
                                    r_present[s_in_hnd] <= 1'b0;
                                    r_count <= r_count - 1'b1;
                                    r_state <= S_RDL;
                                end
                            end
                            OP_POP: begin
                                if (r_count == '0) begin
                                    r_ostatus <= ST_NONE;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_state <= S_RD0;
                                end
                            end
                            default: begin
                                r_ostatus <= ST_DONE;
                                r_state   <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD0: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (ahead(r_dir, r_thr, r_rd_data.key)) begin
                        r_ostatus <= ST_POPPED;
                        r_opop    <= r_rd_data.hnd;
                        r_present[r_rd_data.hnd] <= 1'b0;
                        r_count   <= r_count - 1'b1;
                        r_at      <= '0;
                        r_state   <= S_RDL;
                    end else begin
                        r_ostatus <= ST_NONE;
                        r_state   <= S_DONE;
                    end
                end
                S_RDL: begin
                    // Position of the removed handle: from the memory for a
                    // remove, slot 0 for a pop.
                    if (r_op == OP_REMOVE) begin
                        r_at <= r_prd_data;
                    end
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    // The removed entry was the last one: nothing moves.
                    r_cur <= r_rd_data;
                    if (CNT_BITS'(r_at) >= r_count) begin
                        r_state <= S_DONE;
                    end else if (r_at == '0) begin
                        r_state <= S_DRDL;
                    end else begin
                        r_state <= S_URD;
                    end
                end
                S_URD: begin
                    r_state <= S_UCMP;
                end
                S_UCMP: begin
                    if (ahead(r_dir, r_cur.key, r_rd_data.key)) begin
                        r_at <= s_parent;
                        if (s_parent != '0) begin
                            r_state <= S_URD;
                        end else if (r_op == OP_INSERT) begin
                            r_state <= S_UFIN;
                        end else begin
                            r_state <= S_DRDL;
                        end
                    end else if (r_op == OP_INSERT) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DRDL;
                    end
                end
                S_UFIN: begin
                    r_state <= S_DONE;
                end
                S_DRDL: begin
                    if (s_left >= r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DRDR;
                    end
                end
                S_DRDR: begin
                    r_bestent <= r_rd_data;
                    r_best    <= SLOT_BITS'(s_left);
                    r_haver   <= s_right < {1'b0, r_count};
                    r_state   <= S_DCMP;
                end
                S_DCMP: begin
                    if (ahead(r_dir, s_best_ent.key, r_cur.key)) begin
                        r_at    <= s_best_idx;
                        r_state <= S_DRDL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
